FILE: rtl/jsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_pkg
// shared types and constants of the json string unescaper
// ---------------------------------------------------------------------------
package jsu_pkg;

  // queue between front and back
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);
  localparam int QCw    = $clog2(QDepth + 1);

  localparam int CpW = 21;

  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // what one queue entry expands to
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,  // one raw byte in cp[7:0]
    KIND_ESC  = 2'd1,  // backslash then cp[7:0]
    KIND_CP   = 2'd2   // code point, utf-8 encoded
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [CpW-1:0]  cp;
  } entry_t;

endpackage : jsu_pkg
`default_nettype wire

FILE: rtl/jsu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_front
// escape decoder: takes input bytes, tracks escape state, queues work
// ---------------------------------------------------------------------------
module jsu_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire logic           first,
  input  wire logic           last,
  input  wire logic           framed,
  output logic                push_valid,
  output jsu_pkg::entry_t     push_data
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  localparam logic [7:0]  CH_B      = 8'h62;
  localparam logic [7:0]  CH_F      = 8'h66;
  localparam logic [7:0]  CH_N      = 8'h6E;
  localparam logic [7:0]  CH_R      = 8'h72;
  localparam logic [7:0]  CH_T      = 8'h74;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [7:0]  CH_QUOTE  = 8'h22;
  localparam logic [7:0]  CH_SLASH  = 8'h2F;
  localparam logic [15:0] HIGH_LO   = 16'hD800;
  localparam logic [15:0] HIGH_HI   = 16'hDBFF;
  localparam logic [15:0] LOW_LO    = 16'hDC00;
  localparam logic [15:0] LOW_HI    = 16'hDFFF;
  localparam logic [CpW-1:0] SUPP_BASE = 21'h10000;
  localparam logic [2:0]  HEX_COUNT = 3'd4;

  mode_t       mode, mode_next;
  logic [2:0]  digits_left, digits_left_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_ended, hex_ended_next;
  logic [15:0] pending_high, pending_high_next;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  always_comb begin
    mode_t       m;
    logic [2:0]  dl, dl_dec;
    logic [15:0] hv, ph, v_new;
    logic        he, e_new, emit, handle;
    logic [4:0]  dig;

    // state as seen by this byte; a first byte starts clean
    m  = first ? MODE_NORMAL : mode;
    dl = first ? 3'd0  : digits_left;
    hv = first ? 16'd0 : hex_value;
    he = first ? 1'b0  : hex_ended;
    ph = first ? 16'd0 : pending_high;

    mode_next         = m;
    digits_left_next  = dl;
    hex_value_next    = hv;
    hex_ended_next    = he;
    pending_high_next = ph;
    emit              = 1'b0;
    push_data.kind    = KIND_BYTE;
    push_data.cp      = {13'd0, in_byte};

    dig    = hex_digit(in_byte);
    v_new  = hv;
    e_new  = he;
    dl_dec = (dl != 3'd0) ? dl - 3'd1 : 3'd0;
    handle = !(framed && (first != last));

    if (handle) begin
      unique case (m)
        MODE_HEX: begin
          if (!he && dig[4]) v_new = {hv[11:0], dig[3:0]};
          else               e_new = 1'b1;
          digits_left_next = dl_dec;
          if (dl_dec == 3'd0) begin
            mode_next      = MODE_NORMAL;
            hex_value_next = 16'd0;
            hex_ended_next = 1'b0;
            if (ph != 16'd0) begin
              pending_high_next = 16'd0;
              if (v_new >= LOW_LO && v_new <= LOW_HI) begin
                emit           = 1'b1;
                push_data.kind = KIND_CP;
                push_data.cp   = {1'b0, ph[9:0], v_new[9:0]} + SUPP_BASE;
              end else if (v_new == 16'd0) begin
                // lone high surrogate closed by a zero value
                emit           = 1'b1;
                push_data.kind = KIND_CP;
                push_data.cp   = {5'd0, ph};
              end
            end else if (v_new >= HIGH_LO && v_new <= HIGH_HI) begin
              pending_high_next = v_new;
            end else begin
              emit           = 1'b1;
              push_data.kind = KIND_CP;
              push_data.cp   = {5'd0, v_new};
            end
          end else begin
            hex_value_next = v_new;
            hex_ended_next = e_new;
          end
        end
        MODE_ESCAPE: begin
          mode_next = MODE_NORMAL;
          emit      = 1'b1;
          unique case (in_byte)
            CH_B: push_data.cp = 21'h08;
            CH_F: push_data.cp = 21'h0C;
            CH_N: push_data.cp = 21'h0A;
            CH_R: push_data.cp = 21'h0D;
            CH_T: push_data.cp = 21'h09;
            CH_QUOTE, CH_BSLASH, CH_SLASH: push_data.cp = {13'd0, in_byte};
            CH_U: begin
              emit             = 1'b0;
              mode_next        = MODE_HEX;
              digits_left_next = HEX_COUNT;
              hex_value_next   = 16'd0;
              hex_ended_next   = 1'b0;
            end
            default: push_data.kind = KIND_ESC;
          endcase
        end
        default: begin
          if (in_byte == CH_BSLASH) mode_next = MODE_ESCAPE;
          else                      emit = 1'b1;
        end
      endcase
    end

    // end of string clears everything, unfinished escapes are dropped
    if (last) begin
      mode_next         = MODE_NORMAL;
      digits_left_next  = 3'd0;
      hex_value_next    = 16'd0;
      hex_ended_next    = 1'b0;
      pending_high_next = 16'd0;
    end

    push_valid = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_NORMAL;
      digits_left  <= 3'd0;
      hex_value    <= 16'd0;
      hex_ended    <= 1'b0;
      pending_high <= 16'd0;
    end else if (accept) begin
      mode         <= mode_next;
      digits_left  <= digits_left_next;
      hex_value    <= hex_value_next;
      hex_ended    <= hex_ended_next;
      pending_high <= pending_high_next;
    end
  end

endmodule : jsu_front
`default_nettype wire

FILE: rtl/jsu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_queue
// short fifo of decoded entries between front and back
// ---------------------------------------------------------------------------
module jsu_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire jsu_pkg::entry_t push_data,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output jsu_pkg::entry_t      pop_data
);
  import jsu_pkg::*;

  entry_t           slots [QDepth];
  logic [QAw-1:0]   wr_ptr, rd_ptr;
  logic [QCw-1:0]   count;
  logic             push, pop;

  assign push_ready = (count != QCw'(QDepth));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAw'(1);
      if (pop)  rd_ptr <= rd_ptr + QAw'(1);
      if (push && !pop)      count <= count + QCw'(1);
      else if (pop && !push) count <= count - QCw'(1);
    end
  end

endmodule : jsu_queue
`default_nettype wire

FILE: rtl/jsu_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// jsu_back
// expands queue entries into output bytes, utf-8 encoding code points
// ---------------------------------------------------------------------------
module jsu_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire jsu_pkg::entry_t head,
  output logic                 head_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last
);
  import jsu_pkg::*;

  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;
  localparam logic [7:0] CONT  = 8'h80;

  logic [1:0] idx;
  logic [2:0] len;
  logic [5:0] b0, b1, b2, b3;

  // six-bit groups, least significant first
  assign b0 = head.cp[5:0];
  assign b1 = head.cp[11:6];
  assign b2 = head.cp[17:12];
  assign b3 = {3'd0, head.cp[20:18]};

  always_comb begin
    len      = 3'd1;
    out_byte = head.cp[7:0];
    unique case (head.kind)
      KIND_ESC: begin
        len      = 3'd2;
        out_byte = (idx == 2'd0) ? CH_BSLASH : head.cp[7:0];
      end
      KIND_CP: begin
        if (head.cp < 21'h80) begin
          len = 3'd1;
        end else if (head.cp <= 21'h7FF) begin
          len = 3'd2;
          out_byte = (idx == 2'd0) ? (LEAD2 | {3'd0, b1[4:0]}) : (CONT | {2'd0, b0});
        end else if (head.cp <= 21'hFFFF) begin
          len = 3'd3;
          unique case (idx)
            2'd0:    out_byte = LEAD3 | {4'd0, b2[3:0]};
            2'd1:    out_byte = CONT | {2'd0, b1};
            default: out_byte = CONT | {2'd0, b0};
          endcase
        end else begin
          len = 3'd4;
          unique case (idx)
            2'd0:    out_byte = LEAD4 | {2'd0, b3};
            2'd1:    out_byte = CONT | {2'd0, b2};
            2'd2:    out_byte = CONT | {2'd0, b1};
            default: out_byte = CONT | {2'd0, b0};
          endcase
        end
      end
      default: len = 3'd1;
    endcase
  end

  assign out_valid = head_valid;
  assign run_last  = ({1'b0, idx} == len - 3'd1);
  assign head_pop  = out_valid && out_ready && run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule : jsu_back
`default_nettype wire

FILE: rtl/json_string_unescaper_utf8.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// json_string_unescaper_utf8
// JSON string body unescaper with UTF-8 output
// ---------------------------------------------------------------------------
// Takes an escaped JSON string body one byte per transfer and delivers the
// unescaped bytes, one per transfer, with run_last on the final byte caused
// by each input byte; inputs that cause nothing (backslash, hex digits, a
// held high surrogate, framing quotes) produce no output transfer at all.
// A new input byte is taken every cycle while the four-entry queue between
// the decoder and the output stage has room. An input's first output byte
// is queued and shows once it reaches the head; the output stage then gives
// one byte per cycle while out_ready is high, so an input expanding to n
// bytes (n up to 4, for a surrogate pair) holds the output side for all n
// bytes and the queue absorbs the difference. Steady-state input throughput
// is limited by output byte count: one input per cycle for plain text.
// ---------------------------------------------------------------------------
module json_string_unescaper_utf8 (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       first,
  input  wire logic       last,
  input  wire logic       framed,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last
);
  import jsu_pkg::*;

  logic   in_accept;
  logic   push_valid, push_ready;
  entry_t push_data;
  logic   head_valid, head_pop;
  entry_t head;

  // input transfer only when the queue can take whatever it produces
  assign in_ready  = push_ready;
  assign in_accept = in_valid && in_ready;

  // front: escape and surrogate decoding, one byte per cycle while the queue has room
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .in_byte    (in_byte),
    .first      (first),
    .last       (last),
    .framed     (framed),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // decoupling queue
  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (head_valid),
    .pop_ready  (head_pop),
    .pop_data   (head)
  );

  // back: byte expansion and utf-8 encoding
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  // nothing comes out straight after reset
  a_reset_quiet : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // the decoder never pushes into a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("queue overflow");

  // output cannot appear from an empty queue without a push
  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    (!head_valid && !push_valid) |=> !out_valid)
    else $error("output without decoded entry");

  // an entry is only retired on its final byte
  a_pop_on_last : assert property (@(posedge clk) disable iff (rst)
    head_pop |-> (run_last && out_valid && out_ready))
    else $error("entry retired early");

endmodule : json_string_unescaper_utf8
`default_nettype wire

FILE: sim/unescape_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unescape_checker
// watches both channels of the json string unescaper, predicts the bytes
// each input transfer must produce and compares them in order
// ---------------------------------------------------------------------------
module unescape_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       first,
  input  wire logic       last,
  input  wire logic       framed,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       run_last,
  output int              fail_count,
  output int              bytes_waiting,
  output int              bytes_checked
);

  localparam int MAX_REPORTS = 10;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6E;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LU    = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [31:0] HIGH_MIN    = 32'hD800;
  localparam logic [31:0] HIGH_MAX    = 32'hDBFF;
  localparam logic [31:0] LOW_MIN     = 32'hDC00;
  localparam logic [31:0] LOW_MAX     = 32'hDFFF;
  localparam logic [31:0] PAIR_OFFSET = 32'h35FDC00;
  localparam logic [31:0] CP_MAX      = 32'h10FFFF;

  typedef enum logic [1:0] {
    DEC_PLAIN  = 2'd0,
    DEC_ESCAPE = 2'd1,
    DEC_HEX    = 2'd2
  } dec_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       tail;
  } utf8_byte_t;

  dec_mode_t   mode;
  logic [2:0]  digits_left;
  logic [15:0] hex_acc;
  logic        hex_stop;
  logic [15:0] held_high;

  logic [7:0]  burst [4];
  int          burst_n;
  utf8_byte_t  bytes_due [$];

  int errs    = 0;
  int checked = 0;
  int waiting = 0;

  assign fail_count    = errs;
  assign bytes_checked = checked;
  assign bytes_waiting = waiting;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 32'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 32'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 32'h41 + 10;
    return -1;
  endfunction

  task automatic clear_decoder();
    mode        = DEC_PLAIN;
    digits_left = 3'd0;
    hex_acc     = 16'h0;
    hex_stop    = 1'b0;
    held_high   = 16'h0;
  endtask

  task automatic emit(input logic [7:0] b);
    if (burst_n < 4) begin
      burst[burst_n] = b;
      burst_n++;
    end
  endtask

  task automatic emit_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      emit(cp[7:0]);
    end else if (cp <= 32'h7FF) begin
      emit(8'hC0 | {3'b0, cp[10:6]});
      emit(8'h80 | {2'b0, cp[5:0]});
    end else if (cp <= 32'hFFFF) begin
      emit(8'hE0 | {4'b0, cp[15:12]});
      emit(8'h80 | {2'b0, cp[11:6]});
      emit(8'h80 | {2'b0, cp[5:0]});
    end else if (cp <= CP_MAX) begin
      emit(8'hF0 | {5'b0, cp[20:18]});
      emit(8'h80 | {2'b0, cp[17:12]});
      emit(8'h80 | {2'b0, cp[11:6]});
      emit(8'h80 | {2'b0, cp[5:0]});
    end
  endtask

  // a held high surrogate takes the next value as its partner
  task automatic close_hex();
    logic [31:0] cp;
    cp = {16'h0, hex_acc};
    if (held_high != 16'h0) begin
      if (cp >= LOW_MIN && cp <= LOW_MAX)
        emit_utf8(({16'h0, held_high} << 10) + cp - PAIR_OFFSET);
      else if (cp == 32'h0)
        emit_utf8({16'h0, held_high});
      held_high = 16'h0;
    end else if (cp >= HIGH_MIN && cp <= HIGH_MAX) begin
      held_high = hex_acc;
    end else begin
      emit_utf8(cp);
    end
  endtask

  task automatic decode_byte(input logic [7:0] c);
    int d;
    case (mode)
      DEC_HEX: begin
        d = hex_nibble(c);
        if (!hex_stop && d >= 0) hex_acc = {hex_acc[11:0], d[3:0]};
        else hex_stop = 1'b1;
        if (digits_left > 0) digits_left--;
        if (digits_left == 0) begin
          mode = DEC_PLAIN;
          close_hex();
          hex_acc  = 16'h0;
          hex_stop = 1'b0;
        end
      end
      DEC_ESCAPE: begin
        mode = DEC_PLAIN;
        case (c)
          CH_LB: emit(CTL_BS);
          CH_LF: emit(CTL_FF);
          CH_LN: emit(CTL_LF);
          CH_LR: emit(CTL_CR);
          CH_LT: emit(CTL_HT);
          CH_QUOTE, jsu_pkg::CH_BSLASH, CH_SLASH: emit(c);
          CH_LU: begin
            mode        = DEC_HEX;
            digits_left = 3'd4;
            hex_acc     = 16'h0;
            hex_stop    = 1'b0;
          end
          default: begin
            emit(jsu_pkg::CH_BSLASH);
            emit(c);
          end
        endcase
      end
      default: begin
        if (c == jsu_pkg::CH_BSLASH) mode = DEC_ESCAPE;
        else emit(c);
      end
    endcase
  endtask

  task automatic predict_transfer(input logic [7:0] b, input logic f, input logic l,
                                  input logic fr);
    burst_n = 0;
    if (f) clear_decoder();
    // framing quotes are dropped, except on a one-byte string
    if (!(fr && (f != l))) decode_byte(b);
    if (l) clear_decoder();
    for (int i = 0; i < burst_n; i++)
      bytes_due.push_back('{data: burst[i], tail: (i == burst_n - 1)});
  endtask

  task automatic report(input string msg);
    errs++;
    if (errs <= MAX_REPORTS) $display("%s", msg);
  endtask

  always @(posedge clk) begin : watch
    utf8_byte_t want;
    if (rst) begin
      clear_decoder();
      bytes_due.delete();
    end else begin
      if (in_valid && in_ready) predict_transfer(in_byte, first, last, framed);
      if (out_valid && out_ready) begin
        checked++;
        if (bytes_due.size() == 0) begin
          report($sformatf("unexpected output: out_byte %02h run_last %0b",
                           out_byte, run_last));
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.data || run_last !== want.tail)
            report($sformatf("mismatch: expected out_byte %02h run_last %0b, got %02h %0b",
                             want.data, want.tail, out_byte, run_last));
        end
      end
    end
    waiting = bytes_due.size();
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// testbench for the json string unescaper with utf-8 output
// ---------------------------------------------------------------------------
// drives escaped string bodies into the block: a few directed strings, then
// random strings made mostly of well-formed escapes, unicode escapes and
// surrogate pairs, with some noise. the checker beside the block predicts
// and compares every output transfer; this module makes the stimulus, the
// receiver back-pressure and the verdict
// ---------------------------------------------------------------------------
module tb_top;

  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int TARGET_ITEMS = 100;
  localparam int LIMIT_NS     = 2_000_000;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LU    = 8'h75;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte  = 8'h00;
  logic       first    = 1'b0;
  logic       last     = 1'b0;
  logic       framed   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_last;

  int fails;
  int waiting;
  int checked;

  // idle chances in percent, per phase
  int   tx_idle_pct = 7;
  int   rx_idle_pct = 85;
  logic hold_req    = 1'b0;

  int items_sent   = 0;
  int strings_sent = 0;

  // bytes of the string being built
  logic [7:0] str_q [$];

  json_string_unescaper_utf8 DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .first     (first),
    .last      (last),
    .framed    (framed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  unescape_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .first         (first),
    .last          (last),
    .framed        (framed),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .run_last      (run_last),
    .fail_count    (fails),
    .bytes_waiting (waiting),
    .bytes_checked (checked)
  );

  always #5 clk = ~clk;

  // receiver: random stalls, plus one long hold-off so the queue fills
  initial begin : receiver
    logic hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // overall time limit
  initial begin
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
  endfunction

  // bytes that stop a hex value early
  function automatic logic [7:0] non_hex_char(input int k);
    case (k)
      0:       return 8'h67;  // g
      1:       return 8'h78;  // x
      2:       return 8'h20;  // space
      3:       return 8'h2D;  // minus
      default: return 8'hC8;
    endcase
  endfunction

  // characters after a backslash: the named escapes, then anything
  function automatic logic [7:0] esc_char(input int k);
    case (k)
      0:       return 8'h62;  // b
      1:       return 8'h66;  // f
      2:       return 8'h6E;  // n
      3:       return 8'h72;  // r
      4:       return 8'h74;  // t
      5:       return CH_QUOTE;
      6:       return jsu_pkg::CH_BSLASH;
      7:       return 8'h2F;  // slash
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // code points at the utf-8 length boundaries and surrogate limits
  function automatic logic [15:0] edge_value(input int k);
    case (k)
      0:       return 16'h0000;
      1:       return 16'h007F;
      2:       return 16'h0080;
      3:       return 16'h07FF;
      4:       return 16'h0800;
      5:       return 16'hFFFF;
      6:       return 16'hD800;
      7:       return 16'hDBFF;
      8:       return 16'hDC00;
      default: return 16'hDFFF;
    endcase
  endfunction

  task automatic push_b(input logic [7:0] b);
    str_q.push_back(b);
  endtask

  // a unicode escape, one digit optionally spoilt
  task automatic push_u(input logic [15:0] v, input bit spoil);
    int pos;
    logic [7:0] ch;
    pos = $urandom_range(0, 3);
    push_b(jsu_pkg::CH_BSLASH);
    push_b(CH_LU);
    for (int k = 3; k >= 0; k--) begin
      ch = hex_char(v[k*4 +: 4], 1'($urandom_range(0, 1)));
      if (spoil && k == pos) ch = non_hex_char($urandom_range(0, 4));
      push_b(ch);
    end
  endtask

  // one transfer; valid stays high into the next item unless idling
  task automatic send_item(input logic [7:0] b, input logic f, input logic l,
                           input logic fr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    first    <= f;
    last     <= l;
    framed   <= fr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_string(input bit fr, input bit with_first);
    for (int i = 0; i < str_q.size(); i++)
      send_item(str_q[i], with_first && (i == 0), i == str_q.size() - 1, fr);
    strings_sent++;
    str_q.delete();
  endtask

  task automatic build_random_string(output bit fr);
    int ntok;
    int sel;
    int m;
    logic [15:0] v;
    ntok = $urandom_range(1, 5);
    str_q.delete();
    for (int t = 0; t < ntok; t++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
        push_b(8'($urandom_range(0, 255)));
      end else if (sel < 50) begin
        push_b(jsu_pkg::CH_BSLASH);
        push_b(esc_char($urandom_range(0, 9)));
      end else if (sel < 75) begin
        if ($urandom_range(0, 1)) v = 16'($urandom_range(0, 16'hFFFF));
        else v = edge_value($urandom_range(0, 9));
        push_u(v, $urandom_range(0, 9) == 0);
      end else if (sel < 92) begin
        // high surrogate and a partner: low, zero or anything
        push_u(16'(16'hD800 + $urandom_range(0, 16'h3FF)), 1'b0);
        if ($urandom_range(0, 3) == 0) push_b(8'($urandom_range(8'h41, 8'h5A)));
        case ($urandom_range(0, 3))
          0, 1:    push_u(16'(16'hDC00 + $urandom_range(0, 16'h3FF)), 1'b0);
          2:       push_u(16'h0000, 1'b0);
          default: push_u(16'($urandom_range(0, 16'hFFFF)), 1'b0);
        endcase
      end else begin
        // lone high surrogate, left held
        push_u(16'(16'hD800 + $urandom_range(0, 16'h3FF)), 1'b0);
      end
    end
    // sometimes an escape cut short by the end of the string
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      push_b(jsu_pkg::CH_BSLASH);
    end else if (sel == 1) begin
      push_b(jsu_pkg::CH_BSLASH);
      push_b(CH_LU);
      m = $urandom_range(0, 3);
      for (int k = 0; k < m; k++) push_b(hex_char(4'($urandom_range(0, 15)), 1'b1));
    end
    fr = ($urandom_range(0, 3) == 0);
    if (fr) begin
      str_q.push_front(CH_QUOTE);
      str_q.push_back(CH_QUOTE);
    end
  endtask

  // stray bytes with random flags
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n)
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
    strings_sent++;
  endtask

  initial begin : stimulus
    bit fr;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // one-byte string flagged as framed is kept
    push_b(8'h00);
    send_string(1'b1, 1'b1);
    push_b(8'hFF);
    send_string(1'b0, 1'b1);
    // framed string with a newline escape inside
    push_b(CH_QUOTE);
    push_b(jsu_pkg::CH_BSLASH);
    push_b(8'h6E);
    push_b(CH_QUOTE);
    send_string(1'b1, 1'b1);
    // surrogate pair giving four utf-8 bytes
    push_u(16'hD83D, 1'b0);
    push_u(16'hDE00, 1'b0);
    send_string(1'b0, 1'b1);
    // non-hex byte ends the value after one digit
    push_b(jsu_pkg::CH_BSLASH);
    push_b(CH_LU);
    push_b(8'h31);
    push_b(8'h67);
    push_b(8'h7A);
    push_b(8'h7A);
    send_string(1'b0, 1'b1);

    // long receiver hold-off while the sender keeps offering
    hold_req <= 1'b1;

    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= 70) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end else if (items_sent >= 40) begin
        tx_idle_pct = 85;
        rx_idle_pct <= 7;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        build_random_string(fr);
        send_string(fr, $urandom_range(0, 9) != 0);
      end
    end
    in_valid <= 1'b0;

    // drain, then a few more cycles to catch stray output
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input bytes in %0d strings, %0d output bytes checked",
             items_sent, strings_sent, checked);
    $display("with escapes, unicode escapes, surrogate pairs, framing and stalls");
    if (fails == 0 && waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
